/* sv/j2k_pkg.sv */
// Shared types and constants for the codestream marker parser.
// Holds the item structs, event codes and the marker segment table.
// No dependencies.
package j2k_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_stream;
  } j2k_in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  marker_code;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        last_of_segment;
  } j2k_out_t;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_SEGMENT = 3'd1;
  localparam logic [2:0] EV_PAYLOAD = 3'd2;
  localparam logic [2:0] EV_NOSEG   = 3'd3;
  localparam logic [2:0] EV_SOD     = 3'd4;
  localparam logic [2:0] EV_NOFF    = 3'd5;
  localparam logic [2:0] EV_SHORT   = 3'd6;

  localparam logic [7:0]  PREFIX_BYTE  = 8'hFF;
  localparam logic [7:0]  MARKER_SOD   = 8'h93;
  localparam logic [15:0] LEN_TABLE_LO = 16'hFF00;
  localparam logic [15:0] LEN_HEADER   = 16'd2;

  // Marker table: 1 where the marker carries a segment.
  function automatic logic has_segment(input logic [7:0] m);
    logic seg;
    case (m) inside
      8'h00, 8'h01, [8'h30:8'h3F], 8'h4F, 8'h92, 8'h93, [8'hD0:8'hD9], 8'hFF:
        seg = 1'b0;
      default:
        seg = 1'b1;
    endcase
    return seg;
  endfunction

endpackage

/* sv/j2k_codestream_marker_parser.sv */
// Codestream marker segment parser: one header byte in, one event out.
// Each accepted byte's result is registered in the output register.
// Throughput: 1 byte per cycle; the single output register refills in the
// cycle it is taken, so input stalls only while a held result is stalled.
// Reset (rst_n low, synchronous): parser expects the first 0xFF prefix,
// marker, length and byte count clear, output register empty.
module j2k_codestream_marker_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  j2k_pkg::j2k_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output j2k_pkg::j2k_out_t  out_data
);
  import j2k_pkg::*;

  typedef enum logic [5:0] {
    PH_EXPECT_FF = 6'b000001,
    PH_MARKER    = 6'b000010,
    PH_LEN_HI    = 6'b000100,
    PH_LEN_LO    = 6'b001000,
    PH_PAYLOAD   = 6'b010000,
    PH_HALTED    = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_cur;
  logic [7:0]  marker_r, marker_nxt, marker_cur;
  logic [7:0]  len_hi_r, len_hi_nxt, len_hi_cur;
  logic [15:0] remain_r, remain_nxt, remain_cur;
  logic        out_valid_r, out_valid_nxt;
  j2k_out_t    out_data_r, res_nxt;

  logic        in_acc;
  logic [7:0]  b;
  logic [15:0] seg_len;
  logic [15:0] remain_dec;
  logic        seg;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    b          = in_data.byte_value;
    phase_cur  = in_data.start_of_stream ? PH_EXPECT_FF : phase_r;
    marker_cur = in_data.start_of_stream ? 8'h00 : marker_r;
    len_hi_cur = in_data.start_of_stream ? 8'h00 : len_hi_r;
    remain_cur = in_data.start_of_stream ? 16'h0000 : remain_r;

    seg_len    = {len_hi_cur, b};
    seg        = (seg_len >= LEN_TABLE_LO) ? has_segment(marker_cur) : 1'b1;
    remain_dec = (remain_cur != 16'h0000) ? remain_cur - 16'd1 : remain_cur;

    phase_nxt  = phase_cur;
    marker_nxt = marker_cur;
    len_hi_nxt = len_hi_cur;
    remain_nxt = remain_cur;

    res_nxt                 = '0;
    res_nxt.event_res       = EV_NONE;

    case (phase_cur)
      PH_EXPECT_FF: begin
        if (b == PREFIX_BYTE) begin
          phase_nxt = PH_MARKER;
        end else begin
          res_nxt.event_res = EV_NOFF;
          phase_nxt         = PH_HALTED;
        end
      end
      PH_MARKER: begin
        marker_nxt = b;
        if (b == MARKER_SOD) begin
          res_nxt.event_res = EV_SOD;
          phase_nxt         = PH_HALTED;
        end else begin
          phase_nxt = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        // SOD can arrive as the low byte of a marker without a segment
        if (marker_cur == MARKER_SOD) begin
          res_nxt.event_res = EV_SOD;
          phase_nxt         = PH_HALTED;
        end else begin
          len_hi_nxt = b;
          phase_nxt  = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        if (!seg) begin
          // the two length bytes were really the next marker
          res_nxt.event_res = EV_NOSEG;
          marker_nxt        = b;
          phase_nxt         = PH_LEN_HI;
        end else if (seg_len < LEN_HEADER) begin
          res_nxt.event_res = EV_SHORT;
          phase_nxt         = PH_HALTED;
        end else begin
          res_nxt.event_res      = EV_SEGMENT;
          res_nxt.payload_length = seg_len - LEN_HEADER;
          remain_nxt             = seg_len - LEN_HEADER;
          if (seg_len == LEN_HEADER) begin
            res_nxt.last_of_segment = 1'b1;
            phase_nxt               = PH_EXPECT_FF;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_nxt.event_res = EV_PAYLOAD;
        res_nxt.data_byte = b;
        remain_nxt        = remain_dec;
        if (remain_dec == 16'h0000) begin
          res_nxt.last_of_segment = 1'b1;
          phase_nxt               = PH_EXPECT_FF;
        end
      end
      default: begin
        phase_nxt = PH_HALTED;
      end
    endcase

    // a marker without a segment reports the marker it replaces
    res_nxt.marker_code = (res_nxt.event_res == EV_NOSEG) ? marker_cur : marker_nxt;

    out_valid_nxt = in_acc | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_EXPECT_FF;
      marker_r    <= 8'h00;
      len_hi_r    <= 8'h00;
      remain_r    <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r  <= phase_nxt;
        marker_r <= marker_nxt;
        len_hi_r <= len_hi_nxt;
        remain_r <= remain_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res_nxt;
    end
  end

  a_halt_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (res_nxt.event_res == EV_SOD || res_nxt.event_res == EV_NOFF ||
               res_nxt.event_res == EV_SHORT)
    |=> phase_r == PH_HALTED)
    else $error("parser not halted after SOD or error");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> remain_r != 16'h0000)
    else $error("payload phase with no bytes remaining");

  a_empty_segment: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.event_res == EV_SEGMENT && out_data_r.last_of_segment
    |-> out_data_r.payload_length == 16'h0000)
    else $error("empty segment flagged with non-zero length");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

endmodule
